FILE: hw/rtl/tick_pattern_sequencer_macros.svh
// Assertion macros shared by the sequencer RTL
`ifndef TICK_PATTERN_SEQUENCER_MACROS_SVH
`define TICK_PATTERN_SEQUENCER_MACROS_SVH

// Plain property, clocked on clk_i, off during reset
`define TPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define TPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tps_pkg.sv
// Shared types and constants of the tick pattern sequencer
`timescale 1ns / 1ps
package tps_pkg;

  localparam int unsigned CHANNELS_DEF         = 4;
  localparam int unsigned PATTERN_SLOTS_DEF    = 16;
  localparam int unsigned ROWS_PER_PATTERN_DEF = 64;
  localparam int unsigned ORDER_SLOTS_DEF      = 64;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_ADD_PAT = 3'd1,
    CMD_ROW     = 3'd2,
    CMD_ORDER   = 3'd3,
    CMD_START   = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_e;

  localparam logic ACT_NOTE    = 1'b0;
  localparam logic ACT_SILENCE = 1'b1;

  typedef struct packed {
    logic [23:0] frequency;
    logic [15:0] length;
    logic [3:0]  instrument;
  } row_t;

  typedef struct packed {
    logic [1:0]  channel;
    logic        action;
    logic [23:0] out_frequency;
    logic [3:0]  out_instrument;
    logic        playing;
    logic        last;
  } res_t;

endpackage

FILE: hw/rtl/tps_if.sv
// Command and result channel interfaces
`timescale 1ns / 1ps
interface tps_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  pattern_id;
  logic [6:0]  num_rows;
  logic [5:0]  row_index;
  logic [23:0] note_frequency;
  logic [15:0] note_length;
  logic [3:0]  note_instrument;
  logic [5:0]  order_pos;
  logic [7:0]  order_pattern;
  logic        order_last;

  modport source (output valid, cmd, pattern_id, num_rows, row_index, note_frequency,
                  note_length, note_instrument, order_pos, order_pattern, order_last,
                  input ready);
  modport sink (input valid, cmd, pattern_id, num_rows, row_index, note_frequency,
                note_length, note_instrument, order_pos, order_pattern, order_last,
                output ready);
endinterface

interface tps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel;
  logic        action;
  logic [23:0] out_frequency;
  logic [3:0]  out_instrument;
  logic        playing;
  logic        last;

  modport source (output valid, channel, action, out_frequency, out_instrument, playing,
                  last, input ready);
  modport sink (input valid, channel, action, out_frequency, out_instrument, playing,
                last, output ready);
endinterface

FILE: hw/rtl/tps_row_mem.sv
// Note row memory, one write port and one registered read port
`timescale 1ns / 1ps
module tps_row_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  tps_pkg::row_t   wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output tps_pkg::row_t   rdata_o
);

  tps_pkg::row_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/tick_pattern_sequencer.sv
// Tick pattern sequencer top level: command decode, sequencer and result staging
//
//  channel  dir  beat
//  in_i     in   one command (tick, load, start, stop)
//  out_o    out  one channel action (note or silence)
//
// Loads and start complete in the accepting cycle. A tick runs under the sequencer:
// the accepting cycle, the order read, per pattern slot searched an id memory read
// then a compare and an extra search step when the id is missing, then per channel
// a check, plus a wait and a row step when a row is read from the row memory, then
// the end-of-pattern check and the flush of the final beat. Stop and end of order
// add a silence beat per channel. No clearing pass after reset. A stalled result
// port holds the sequencer at its next beat.
`timescale 1ns / 1ps
`include "tick_pattern_sequencer_macros.svh"
module tick_pattern_sequencer #(
  parameter int unsigned CHANNELS         = tps_pkg::CHANNELS_DEF,
  parameter int unsigned PATTERN_SLOTS    = tps_pkg::PATTERN_SLOTS_DEF,
  parameter int unsigned ROWS_PER_PATTERN = tps_pkg::ROWS_PER_PATTERN_DEF,
  parameter int unsigned ORDER_SLOTS      = tps_pkg::ORDER_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tps_in_if.sink    in_i,
  tps_out_if.source out_o
);

  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SW    = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int unsigned UW    = $clog2(PATTERN_SLOTS + 1);
  localparam int unsigned OW    = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int unsigned CELLS = PATTERN_SLOTS * ROWS_PER_PATTERN;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_ORDA  = 11'b000_0000_0010,
    S_ORD   = 11'b000_0000_0100,
    S_SRD   = 11'b000_0000_1000,
    S_SCMP  = 11'b000_0001_0000,
    S_CH    = 11'b000_0010_0000,
    S_RWAIT = 11'b000_0100_0000,
    S_ROW   = 11'b000_1000_0000,
    S_DONE  = 11'b001_0000_0000,
    S_SIL   = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic              running_q, running_d;
  logic [UW-1:0]     slots_used_q, slots_used_d;
  logic [6:0]        order_len_q, order_len_d;
  logic [6:0]        cursor_q, cursor_d;
  logic              miss_q, miss_d;
  logic [7:0]        search_id_q, search_id_d;
  logic [UW-1:0]     search_idx_q, search_idx_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [6:0]        rc_q, rc_d;
  logic [CW-1:0]     ch_q, ch_d;
  logic [6:0]        rows_q [CHANNELS];
  logic [6:0]        rows_d [CHANNELS];
  logic [15:0]       ticks_q [CHANNELS];
  logic [15:0]       ticks_d [CHANNELS];
  logic              ov_q, ov_d;
  tps_pkg::res_t     out_q, out_d;
  logic              pend_v_q, pend_v_d;
  tps_pkg::res_t     pend_q, pend_d;

  // slot tables and order list
  logic [7:0]        slot_id_mem [PATTERN_SLOTS];
  logic [6:0]        slot_rc_mem [PATTERN_SLOTS];
  logic [7:0]        order_mem   [ORDER_SLOTS];
  logic [7:0]        slot_id_rd_q;
  logic [6:0]        slot_rc_rd_q;
  logic [7:0]        ord_rd_q;

  logic              slot_we, row_we, ord_we;
  logic [6:0]        rc_sat;
  logic [AW-1:0]     row_waddr, row_raddr;
  tps_pkg::row_t     row_wdata, row_rd;
  logic              can_emit, emit, fin_push, pat_done;
  tps_pkg::res_t     new_res;
  logic              accept;

  assign accept   = in_i.valid && in_i.ready;
  assign can_emit = !ov_q || out_o.ready;
  assign rc_sat   = (32'(in_i.num_rows) > ROWS_PER_PATTERN) ? 7'(ROWS_PER_PATTERN)
                                                             : in_i.num_rows;
  assign row_waddr = AW'(slots_used_q) * AW'(ROWS_PER_PATTERN) + AW'(in_i.row_index);
  assign row_raddr = AW'(slot_q) * AW'(ROWS_PER_PATTERN) + AW'(rows_q[ch_q]);
  assign row_wdata = '{frequency: in_i.note_frequency, length: in_i.note_length,
                       instrument: in_i.note_instrument};

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_id_mem[SW'(slots_used_q)] <= in_i.pattern_id;
      slot_rc_mem[SW'(slots_used_q)] <= rc_sat;
    end
    slot_id_rd_q <= slot_id_mem[SW'(search_idx_q)];
    slot_rc_rd_q <= slot_rc_mem[SW'(search_idx_q)];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      order_mem[OW'(in_i.order_pos)] <= in_i.order_pattern;
    end
    ord_rd_q <= order_mem[OW'(cursor_q)];
  end

  tps_row_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rd)
  );

  always_comb begin
    pat_done = 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      if (rows_q[c] < rc_q) begin
        pat_done = 1'b0;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    running_d    = running_q;
    slots_used_d = slots_used_q;
    order_len_d  = order_len_q;
    cursor_d     = cursor_q;
    miss_d       = miss_q;
    search_id_d  = search_id_q;
    search_idx_d = search_idx_q;
    slot_d       = slot_q;
    rc_d         = rc_q;
    ch_d         = ch_q;
    rows_d       = rows_q;
    ticks_d      = ticks_q;
    slot_we      = 1'b0;
    row_we       = 1'b0;
    ord_we       = 1'b0;
    emit         = 1'b0;
    fin_push     = 1'b0;
    new_res      = '{channel: 2'(ch_q), action: tps_pkg::ACT_SILENCE, out_frequency: '0,
                     out_instrument: '0, playing: 1'b1, last: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (tps_pkg::cmd_e'(in_i.cmd))
            tps_pkg::CMD_TICK: begin
              if (running_q) begin
                miss_d = 1'b0;
                if (cursor_q >= order_len_q) begin
                  ch_d    = '0;
                  state_d = S_SIL;
                end else begin
                  state_d = S_ORDA;
                end
              end
            end
            tps_pkg::CMD_ADD_PAT: begin
              if (!running_q && 32'(slots_used_q) < PATTERN_SLOTS) begin
                slot_we      = 1'b1;
                slots_used_d = slots_used_q + 1'b1;
              end
            end
            tps_pkg::CMD_ROW: begin
              if (!running_q && 32'(slots_used_q) < PATTERN_SLOTS &&
                  32'(in_i.row_index) < ROWS_PER_PATTERN) begin
                row_we = 1'b1;
              end
            end
            tps_pkg::CMD_ORDER: begin
              if (!running_q && 32'(in_i.order_pos) < ORDER_SLOTS) begin
                ord_we = 1'b1;
                if (in_i.order_last) begin
                  order_len_d = 7'(in_i.order_pos) + 7'd1;
                end
              end
            end
            tps_pkg::CMD_START: begin
              running_d = 1'b1;
              cursor_d  = '0;
              for (int c = 0; c < CHANNELS; c++) begin
                rows_d[c]  = '0;
                ticks_d[c] = '0;
              end
            end
            tps_pkg::CMD_STOP: begin
              ch_d    = '0;
              state_d = S_SIL;
            end
            default: ;
          endcase
        end
      end
      // order memory read in flight at cursor_q
      S_ORDA: state_d = S_ORD;
      S_ORD: begin
        search_id_d  = ord_rd_q;
        search_idx_d = '0;
        state_d      = S_SRD;
      end
      S_SRD: begin
        if (search_idx_q >= slots_used_q) begin
          // pattern missing: skip one, stop on a second or at the end of the order
          if (miss_q || (cursor_q + 7'd1) >= order_len_q) begin
            ch_d    = '0;
            state_d = S_SIL;
          end else begin
            state_d = S_ORDA;
          end
          miss_d   = 1'b1;
          cursor_d = cursor_q + 7'd1;
        end else begin
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (slot_id_rd_q == search_id_q) begin
          slot_d  = SW'(search_idx_q);
          rc_d    = slot_rc_rd_q;
          ch_d    = '0;
          state_d = S_CH;
        end else begin
          search_idx_d = search_idx_q + 1'b1;
          state_d      = S_SRD;
        end
      end
      S_CH: begin
        if (ticks_q[ch_q] == '0) begin
          if (rows_q[ch_q] < rc_q) begin
            state_d = S_RWAIT;
          end else if (can_emit) begin
            emit = 1'b1;
            if (ch_q == CW'(CHANNELS - 1)) begin
              state_d = S_DONE;
            end else begin
              ch_d = ch_q + 1'b1;
            end
          end
        end else begin
          ticks_d[ch_q] = ticks_q[ch_q] - 16'd1;
          if (ch_q == CW'(CHANNELS - 1)) begin
            state_d = S_DONE;
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end
      end
      S_RWAIT: state_d = S_ROW;
      S_ROW: begin
        if (can_emit) begin
          emit = 1'b1;
          if (row_rd.frequency != '0) begin
            new_res.action         = tps_pkg::ACT_NOTE;
            new_res.out_frequency  = row_rd.frequency;
            new_res.out_instrument = row_rd.instrument;
          end
          ticks_d[ch_q] = (row_rd.length == '0) ? '0 : row_rd.length - 16'd1;
          rows_d[ch_q]  = rows_q[ch_q] + 7'd1;
          if (ch_q == CW'(CHANNELS - 1)) begin
            state_d = S_DONE;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = S_CH;
          end
        end
      end
      S_DONE: begin
        state_d = S_FIN;
        if (pat_done) begin
          cursor_d = cursor_q + 7'd1;
          if ((cursor_q + 7'd1) < order_len_q) begin
            for (int c = 0; c < CHANNELS; c++) begin
              rows_d[c]  = '0;
              ticks_d[c] = '0;
            end
          end else begin
            ch_d    = '0;
            state_d = S_SIL;
          end
        end
      end
      S_SIL: begin
        running_d       = 1'b0;
        new_res.playing = 1'b0;
        if (can_emit) begin
          emit = 1'b1;
          if (ch_q == CW'(CHANNELS - 1)) begin
            state_d = S_FIN;
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end
      end
      S_FIN: begin
        if (can_emit) begin
          fin_push = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // one result is held back so the final beat of a command can carry last
  always_comb begin
    ov_d     = ov_q && !out_o.ready;
    out_d    = out_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    if (emit) begin
      if (pend_v_q) begin
        ov_d       = 1'b1;
        out_d      = pend_q;
        out_d.last = 1'b0;
      end
      pend_d   = new_res;
      pend_v_d = 1'b1;
    end
    if (fin_push) begin
      if (pend_v_q) begin
        ov_d       = 1'b1;
        out_d      = pend_q;
        out_d.last = 1'b1;
      end
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      running_q    <= 1'b0;
      slots_used_q <= '0;
      order_len_q  <= '0;
      cursor_q     <= '0;
      miss_q       <= 1'b0;
      search_idx_q <= '0;
      ch_q         <= '0;
      ov_q         <= 1'b0;
      pend_v_q     <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        rows_q[c]  <= '0;
        ticks_q[c] <= '0;
      end
    end else begin
      state_q      <= state_d;
      running_q    <= running_d;
      slots_used_q <= slots_used_d;
      order_len_q  <= order_len_d;
      cursor_q     <= cursor_d;
      miss_q       <= miss_d;
      search_idx_q <= search_idx_d;
      ch_q         <= ch_d;
      ov_q         <= ov_d;
      pend_v_q     <= pend_v_d;
      rows_q       <= rows_d;
      ticks_q      <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    search_id_q <= search_id_d;
    slot_q      <= slot_d;
    rc_q        <= rc_d;
    out_q       <= out_d;
    pend_q      <= pend_d;
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = ov_q;
  assign out_o.channel        = out_q.channel;
  assign out_o.action         = out_q.action;
  assign out_o.out_frequency  = out_q.out_frequency;
  assign out_o.out_instrument = out_q.out_instrument;
  assign out_o.playing        = out_q.playing;
  assign out_o.last           = out_q.last;

  `TPS_ASSERT_IMPL(a_ready_no_pend, in_i.ready, !pend_v_q, "held result left at idle")
  `TPS_ASSERT_IMPL(a_scan_running, (state_q == S_CH) || (state_q == S_ROW), running_q, "scan stopped")
  `TPS_ASSERT_NEXT(a_fin_idle, (state_q == S_FIN) && can_emit, state_q == S_IDLE, "finish stuck")
  `TPS_ASSERT_IMPL(a_search_bound, state_q == S_SCMP, search_idx_q < slots_used_q, "search overrun")

endmodule
